/* src/edd_pkg.sv */
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types, constants and the error share function of the error
// diffusion dither.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int EDD_MAX_WIDTH = 1024;

  localparam int PIX_W  = 8;
  localparam int LW_W   = 11;
  localparam int ERR_W  = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = 11'd256;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET  = 8'd128;
  localparam int               MIN_LINE_WIDTH   = 2;
  localparam logic [PIX_W-1:0] PIX_MAX          = 8'd255;

  localparam logic [3:0] W_RIGHT       = 4'd7;
  localparam logic [3:0] W_BELOW       = 4'd5;
  localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
  localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

  typedef struct packed {
    logic frame_start;
    logic first_row;
    logic last;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  // floor(err * weight / 16)
  function automatic logic signed [ERR_W-1:0] share16(input logic signed [PIX_W:0] err,
                                                      input logic [3:0] weight);
    logic signed [ERR_W:0] prod;
    logic signed [ERR_W:0] quot;
    prod = (ERR_W+1)'(err) * $signed({{(ERR_W-3){1'b0}}, weight});
    quot = prod >>> 4;
    return quot[ERR_W-1:0];
  endfunction

endpackage

/* src/edd_front.sv */
// ----------------------------------------------------------------------------
// edd_front
// Input side: tracks column and first row, tags each pixel with its
// column, row end and frame start before it goes into the queue.
// ----------------------------------------------------------------------------
module edd_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     frame_start,
  input  logic [edd_pkg::LW_W-1:0] line_width,
  input  logic                     q_full,
  output logic                     in_stall,
  output logic                     push,
  output edd_pkg::ctl_t            ctl,
  output logic [COL_W-1:0]         col
);
  import edd_pkg::*;

  localparam int WW = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

  logic [COL_W-1:0] column;
  logic             first_row;
  logic [WW-1:0]    lw_ext;
  logic [WW-1:0]    lim;
  logic [WW-1:0]    col_p1;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    lw_ext = WW'(line_width);
    if (lw_ext < WW'(MIN_LINE_WIDTH)) begin
      lim = WW'(MIN_LINE_WIDTH);
    end else if (lw_ext > WW'(MAX_WIDTH)) begin
      lim = WW'(MAX_WIDTH);
    end else begin
      lim = lw_ext;
    end
    col     = frame_start ? '0 : column;
    col_p1  = WW'(col) + WW'(1);
    ctl.frame_start = frame_start;
    ctl.first_row   = frame_start || first_row;
    ctl.last        = col_p1 >= lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      first_row <= 1'b1;
    end else if (push) begin
      if (ctl.last) begin
        column    <= '0;
        first_row <= 1'b0;
      end else begin
        column    <= col_p1[COL_W-1:0];
        first_row <= ctl.first_row;
      end
    end
  end

endmodule

/* src/edd_queue.sv */
// ----------------------------------------------------------------------------
// edd_queue
// Short queue between the front and back halves.
// ----------------------------------------------------------------------------
module edd_queue #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);
  import edd_pkg::*;

  logic [W-1:0]      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rdata = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/edd_back.sv */
// ----------------------------------------------------------------------------
// edd_back
// Execution side: row store read, error add and clamp, threshold, error
// shares and the registered result.
// ----------------------------------------------------------------------------
module edd_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  logic [edd_pkg::PIX_W-1:0] q_pixel,
  input  edd_pkg::ctl_t             q_ctl,
  input  logic [COL_W-1:0]          q_col,
  output logic                      pop,
  input  logic [edd_pkg::PIX_W-1:0] white_threshold,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      white,
  output logic                      row_end
);
  import edd_pkg::*;

  localparam int SUM_W = ERR_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-PIX_W){1'b0}}, PIX_MAX};

  logic                    back_en;
  logic                    r_valid;
  logic [PIX_W-1:0]        r_pixel;
  ctl_t                    r_ctl;
  logic [COL_W-1:0]        r_col;
  logic signed [ERR_W-1:0] rd_data;

  logic signed [ERR_W-1:0] right_error;
  logic signed [ERR_W-1:0] below_pending;
  logic signed [ERR_W-1:0] below_right_pending;

  logic                    tail_valid;
  logic [COL_W-1:0]        tail_addr;
  logic signed [ERR_W-1:0] tail_data;

  logic signed [ERR_W-1:0] store [MAX_WIDTH];

  logic signed [ERR_W-1:0] right_in;
  logic signed [ERR_W-1:0] bp_in;
  logic signed [ERR_W-1:0] brp_in;
  logic signed [ERR_W-1:0] below_in;
  logic signed [SUM_W-1:0] sum;
  logic [PIX_W-1:0]        clamped;
  logic                    white_c;
  logic signed [PIX_W:0]   err;
  logic signed [ERR_W-1:0] s1, s3, s5, s7;
  logic signed [ERR_W-1:0] new_bp;
  logic                    dir_en;
  logic [COL_W-1:0]        dir_addr;
  logic signed [ERR_W-1:0] dir_data;

  assign back_en = !out_valid || !out_stall;
  assign pop     = back_en && !q_empty;

  always_comb begin
    right_in = r_ctl.frame_start ? '0 : right_error;
    bp_in    = r_ctl.frame_start ? '0 : below_pending;
    brp_in   = r_ctl.frame_start ? '0 : below_right_pending;
    below_in = r_ctl.first_row   ? '0 : rd_data;
    sum = $signed(SUM_W'(r_pixel)) + SUM_W'(right_in) + SUM_W'(below_in);
    if (sum[SUM_W-1]) begin
      clamped = '0;
    end else if (sum > SUM_MAX) begin
      clamped = PIX_MAX;
    end else begin
      clamped = sum[PIX_W-1:0];
    end
    white_c = clamped >= white_threshold;
    if (white_c) begin
      err = $signed({1'b0, clamped}) - $signed({1'b0, PIX_MAX});
    end else begin
      err = $signed({1'b0, clamped});
    end
    s1 = share16(err, W_BELOW_RIGHT);
    s3 = share16(err, W_BELOW_LEFT);
    s5 = share16(err, W_BELOW);
    s7 = share16(err, W_RIGHT);
    new_bp   = brp_in + s5;
    dir_en   = back_en && r_valid && (r_col != '0);
    dir_addr = r_col - 1'b1;
    dir_data = bp_in + s3;
  end

  // row store: one write a cycle; the row end value is written the cycle
  // after, when the column 0 pixel never writes
  always_ff @(posedge clk) begin
    if (dir_en) begin
      store[dir_addr] <= dir_data;
    end else if (tail_valid) begin
      store[tail_addr] <= tail_data;
    end
    if (back_en) begin
      if (dir_en && dir_addr == q_col) begin
        rd_data <= dir_data;
      end else if (tail_valid && tail_addr == q_col) begin
        rd_data <= tail_data;
      end else begin
        rd_data <= store[q_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      r_pixel   <= q_pixel;
      r_ctl     <= q_ctl;
      r_col     <= q_col;
      white     <= white_c;
      row_end   <= r_ctl.last;
      tail_addr <= r_col;
      tail_data <= new_bp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid             <= 1'b0;
      out_valid           <= 1'b0;
      tail_valid          <= 1'b0;
      right_error         <= '0;
      below_pending       <= '0;
      below_right_pending <= '0;
    end else begin
      tail_valid <= back_en && r_valid && r_ctl.last;
      if (back_en) begin
        r_valid   <= !q_empty;
        out_valid <= r_valid;
        if (r_valid) begin
          if (r_ctl.last) begin
            right_error         <= '0;
            below_pending       <= '0;
            below_right_pending <= '0;
          end else begin
            right_error         <= s7;
            below_pending       <= new_bp;
            below_right_pending <= s1;
          end
        end
      end
    end
  end

endmodule

/* src/error_diffusion_dither.sv */
// ----------------------------------------------------------------------------
// error_diffusion_dither
// 1-bit Floyd-Steinberg dither of an 8-bit grayscale raster stream.
// ----------------------------------------------------------------------------
// a pixel moves from the queue to the execute stage, then the output register
// throughput: one pixel per cycle unless stalled; the right-neighbor error
//   loop closes in the single execute stage; one row store write per cycle
// reset clears control and error state; the row store is not cleared, the
//   first row after reset or frame start reads it as zero
module error_diffusion_dither #(
  parameter int MAX_WIDTH = edd_pkg::EDD_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [edd_pkg::PIX_W-1:0]  pixel,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       white,
  output logic                       row_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edd_pkg::CFG_AW-1:0] paddr,
  input  logic [edd_pkg::CFG_DW-1:0] pwdata,
  output logic [edd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import edd_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = PIX_W + CTL_W + COL_W;

  logic [LW_W-1:0]    line_width;
  logic [PIX_W-1:0]   white_threshold;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  ctl_t               f_ctl;
  logic [COL_W-1:0]   f_col;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  logic [PIX_W-1:0]   q_pixel;
  ctl_t               q_ctl;
  logic [COL_W-1:0]   q_col;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width      <= LINE_WIDTH_RESET;
      white_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[CFG_AW-1])
        REG_LINE_WIDTH: line_width      <= pwdata[LW_W-1:0];
        REG_THRESHOLD:  white_threshold <= pwdata[PIX_W-1:0];
        default:        line_width      <= line_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1])
      REG_LINE_WIDTH: prdata = CFG_DW'(line_width);
      REG_THRESHOLD:  prdata = CFG_DW'(white_threshold);
      default:        prdata = '0;
    endcase
  end

  edd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .frame_start (frame_start),
    .line_width  (line_width),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .push        (push),
    .ctl         (f_ctl),
    .col         (f_col)
  );

  assign q_wdata = {pixel, f_ctl, f_col};

  edd_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  assign {q_pixel, q_ctl, q_col} = q_rdata;

  edd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_pixel         (q_pixel),
    .q_ctl           (q_ctl),
    .q_col           (q_col),
    .pop             (pop),
    .white_threshold (white_threshold),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .white           (white),
    .row_end         (row_end)
  );

endmodule

/* src/edd_checker.sv */
// ----------------------------------------------------------------------------
// edd_checker
// Port-level checks on the dither: occupancy bounds and output handshake.
// ----------------------------------------------------------------------------
module edd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic white,
  input logic row_end
);
  import edd_pkg::*;

  localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;

  logic       in_acc;
  logic       out_acc;
  logic [3:0] inflight;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result without an accepted pixel");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(MAX_INFLIGHT))
    else $error("more pixels in flight than the pipeline holds");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> inflight >= 4'(QUEUE_DEPTH))
    else $error("input stalled while queue has room");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(white) && $stable(row_end))
    else $error("stalled result changed");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);
